// ----- rtl/core/ntte_pkg.sv -----
// Package for the neighbor table with TTL aging.
// Shared constants, codes and types; no dependencies.
package ntte_pkg;

  // table depth, at most 63 so that the count and the limit fit 6 bits
  localparam int DEPTH = 32;
  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = 6;
  localparam logic [IDX_W:0] SCAN_END = (IDX_W + 1)'(DEPTH);
  localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(DEPTH);

  localparam int KEY_W = 64;
  localparam int DIG_W = 64;
  localparam int EXP_W = 32;
  localparam int ENT_W = KEY_W + DIG_W + EXP_W;

  localparam logic [CNT_W-1:0] LIMIT_RST = 6'd32;
  localparam logic [15:0] CAPMASK_RST = 16'hFFFF;

  typedef enum logic [1:0] {
    REG_LIMIT   = 2'd0,
    REG_CAPMASK = 2'd1,
    REG_FILTER  = 2'd2
  } reg_idx_t;

  typedef enum logic [1:0] {
    EV_ADDED     = 2'd0,
    EV_REMOVED   = 2'd1,
    EV_UPDATED   = 2'd2,
    EV_REFRESHED = 2'd3
  } ev_kind_t;

  typedef enum logic {
    OP_ADVERT = 1'b0,
    OP_TICK   = 1'b1
  } op_t;

  typedef enum logic [2:0] {
    B_IDLE,
    B_KEY,
    B_KEYDEC,
    B_MIN,
    B_MINDEC,
    B_INSERT,
    B_FLUSH
  } bstate_t;

  // classified item handed from front to back
  typedef struct packed {
    op_t              op;
    logic [EXP_W-1:0] now;
    logic [KEY_W-1:0] key;
    logic [DIG_W-1:0] digest;
    logic [EXP_W-1:0] expiry;
    logic             keep;
  } item_t;

endpackage

// ----- rtl/core/ntte_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module ntte_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/core/ntte_front.sv -----
// Front end: accepts input transfers, classifies advertisements, and queues
// the classified items for the back end. Depends on ntte_pkg.
module ntte_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                in_op,
  input  logic [31:0]         in_time,
  input  logic [63:0]         in_key,
  input  logic [63:0]         in_digest,
  input  logic [47:0]         in_src,
  input  logic                in_has_caps,
  input  logic [15:0]         in_caps,
  input  logic [15:0]         in_ttl,
  input  logic [15:0]         cap_mask,
  input  logic [47:0]         filtered_source_mac,
  output logic                q_valid,
  input  logic                q_ready,
  output ntte_pkg::item_t     q_item
);

  ntte_pkg::item_t fifo [2];
  logic            wptr;
  logic            rptr;
  logic [1:0]      fill;
  ntte_pkg::item_t cls;
  logic [32:0]     sum;
  logic            push;
  logic            pop;

  always_comb begin
    sum = {1'b0, in_time} + {17'd0, in_ttl};
    cls.op = ntte_pkg::op_t'(in_op);
    cls.now = in_time;
    cls.key = in_key;
    cls.digest = in_digest;
    cls.expiry = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
    cls.keep = (in_ttl != 16'd0)
             && !(filtered_source_mac != 48'd0 && filtered_source_mac == in_src)
             && !(in_has_caps && (in_caps & cap_mask) == 16'd0);
  end

  assign in_ready = (fill != 2'd2);
  assign push = in_valid && in_ready;
  assign q_valid = (fill != 2'd0);
  assign pop = q_valid && q_ready;
  assign q_item = fifo[rptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= 1'b0;
      rptr <= 1'b0;
      fill <= 2'd0;
    end else begin
      if (push) begin
        wptr <= ~wptr;
      end
      if (pop) begin
        rptr <= ~rptr;
      end
      fill <= fill + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      fifo[wptr] <= cls;
    end
  end

endmodule

// ----- rtl/core/ntte_back.sv -----
// Back end: table sequencer with key search, earliest-expiry eviction,
// insertion and event output. Depends on ntte_pkg and ntte_ram.
module ntte_back (
  input  logic                          clk,
  input  logic                          rst,
  input  logic [ntte_pkg::CNT_W-1:0]    neighbor_limit,
  input  logic                          q_valid,
  output logic                          q_ready,
  input  ntte_pkg::item_t               q_item,
  output logic                          ev_valid,
  input  logic                          ev_ready,
  output logic [1:0]                    ev_kind,
  output logic [63:0]                   ev_key,
  output logic [31:0]                   ev_expiry,
  output logic                          ev_last
);

  localparam int IW = ntte_pkg::IDX_W;
  localparam int CW = ntte_pkg::CNT_W;

  ntte_pkg::bstate_t state, state_next;
  ntte_pkg::item_t   cur;
  logic              had_old;

  logic [IW:0]   scan_cnt;
  logic          issuing;
  logic          rd_v;
  logic [IW-1:0] rd_idx;
  logic          scan_done;
  logic          start_scan;

  logic [ntte_pkg::DEPTH-1:0] valid;
  logic [CW-1:0]              count;

  logic          found;
  logic [IW-1:0] f_idx;
  logic [63:0]   f_key;
  logic [63:0]   f_dig;
  logic [31:0]   f_exp;

  logic          best_v;
  logic [IW-1:0] b_idx;
  logic [63:0]   b_key;
  logic [31:0]   b_exp;

  logic                     ram_we;
  logic [IW-1:0]            ram_waddr;
  logic [ntte_pkg::ENT_W-1:0] ram_wdata;
  logic [ntte_pkg::ENT_W-1:0] ram_rdata;
  logic [63:0]              r_key;
  logic [63:0]              r_dig;
  logic [31:0]              r_exp;

  logic          free_v;
  logic [IW-1:0] free_idx;
  logic [CW-1:0] lim;
  logic [CW-1:0] thr;
  logic          emit_ok;

  logic          drop;
  logic [IW-1:0] drop_idx;
  logic          ins;
  logic          set_old;
  logic          ev_fire;
  ntte_pkg::ev_kind_t ev_k;
  logic [63:0]   ev_kk;
  logic [31:0]   ev_ee;
  logic          flush;

  logic          pend_v;
  logic [1:0]    pend_kind;
  logic [63:0]   pend_key;
  logic [31:0]   pend_exp;

  ntte_ram #(
    .WIDTH(ntte_pkg::ENT_W),
    .DEPTH(ntte_pkg::DEPTH)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(scan_cnt[IW-1:0]),
    .rdata(ram_rdata)
  );

  assign {r_key, r_dig, r_exp} = ram_rdata;
  assign issuing = (scan_cnt != ntte_pkg::SCAN_END);
  assign scan_done = !issuing && !rd_v;
  assign emit_ok = !ev_valid || ev_ready;

  always_comb begin
    lim = (neighbor_limit > ntte_pkg::DEPTH_C) ? ntte_pkg::DEPTH_C : neighbor_limit;
    if (cur.op == ntte_pkg::OP_TICK) begin
      thr = lim;
    end else begin
      thr = (lim > CW'(1)) ? lim - CW'(1) : '0;
    end
  end

  always_comb begin
    free_v = 1'b0;
    free_idx = '0;
    for (int i = ntte_pkg::DEPTH - 1; i >= 0; i--) begin
      if (!valid[i]) begin
        free_v = 1'b1;
        free_idx = IW'(i);
      end
    end
  end

  always_comb begin
    state_next = state;
    q_ready = 1'b0;
    start_scan = 1'b0;
    drop = 1'b0;
    drop_idx = f_idx;
    ins = 1'b0;
    set_old = 1'b0;
    ev_fire = 1'b0;
    ev_k = ntte_pkg::EV_REMOVED;
    ev_kk = f_key;
    ev_ee = f_exp;
    flush = 1'b0;
    ram_we = 1'b0;
    ram_waddr = f_idx;
    ram_wdata = {f_key, f_dig, cur.expiry};
    case (state)
      ntte_pkg::B_IDLE: begin
        q_ready = 1'b1;
        if (q_valid) begin
          start_scan = 1'b1;
          state_next = (q_item.op == ntte_pkg::OP_TICK) ? ntte_pkg::B_MIN : ntte_pkg::B_KEY;
        end
      end
      ntte_pkg::B_KEY: begin
        if (scan_done) begin
          state_next = ntte_pkg::B_KEYDEC;
        end
      end
      ntte_pkg::B_KEYDEC: begin
        if (found && !cur.keep) begin
          if (emit_ok) begin
            drop = 1'b1;
            ev_fire = 1'b1;
            state_next = ntte_pkg::B_FLUSH;
          end
        end else if (found && f_dig == cur.digest) begin
          if (emit_ok) begin
            ram_we = 1'b1;
            ev_fire = 1'b1;
            ev_k = ntte_pkg::EV_REFRESHED;
            ev_kk = cur.key;
            ev_ee = cur.expiry;
            state_next = ntte_pkg::B_FLUSH;
          end
        end else if (found) begin
          drop = 1'b1;
          set_old = 1'b1;
          start_scan = 1'b1;
          state_next = ntte_pkg::B_MIN;
        end else if (!cur.keep) begin
          state_next = ntte_pkg::B_FLUSH;
        end else begin
          start_scan = 1'b1;
          state_next = ntte_pkg::B_MIN;
        end
      end
      ntte_pkg::B_MIN: begin
        if (scan_done) begin
          state_next = ntte_pkg::B_MINDEC;
        end
      end
      ntte_pkg::B_MINDEC: begin
        if (best_v && (count > thr || b_exp <= cur.now)) begin
          if (emit_ok) begin
            drop = 1'b1;
            drop_idx = b_idx;
            ev_fire = 1'b1;
            ev_kk = b_key;
            ev_ee = b_exp;
            start_scan = 1'b1;
            state_next = ntte_pkg::B_MIN;
          end
        end else if (cur.op == ntte_pkg::OP_TICK) begin
          state_next = ntte_pkg::B_FLUSH;
        end else begin
          state_next = ntte_pkg::B_INSERT;
        end
      end
      ntte_pkg::B_INSERT: begin
        if (!free_v) begin
          state_next = ntte_pkg::B_FLUSH;
        end else if (emit_ok) begin
          ins = 1'b1;
          ram_we = 1'b1;
          ram_waddr = free_idx;
          ram_wdata = {cur.key, cur.digest, cur.expiry};
          ev_fire = 1'b1;
          ev_k = had_old ? ntte_pkg::EV_UPDATED : ntte_pkg::EV_ADDED;
          ev_kk = cur.key;
          ev_ee = cur.expiry;
          state_next = ntte_pkg::B_FLUSH;
        end
      end
      ntte_pkg::B_FLUSH: begin
        if (emit_ok) begin
          flush = 1'b1;
          state_next = ntte_pkg::B_IDLE;
        end
      end
      default: state_next = ntte_pkg::B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ntte_pkg::B_IDLE;
      scan_cnt <= ntte_pkg::SCAN_END;
      rd_v <= 1'b0;
      valid <= '0;
      count <= '0;
      pend_v <= 1'b0;
      ev_valid <= 1'b0;
      had_old <= 1'b0;
      found <= 1'b0;
      best_v <= 1'b0;
    end else begin
      state <= state_next;
      rd_v <= issuing && !start_scan;
      if (start_scan) begin
        scan_cnt <= '0;
        found <= 1'b0;
        best_v <= 1'b0;
      end else if (issuing) begin
        scan_cnt <= scan_cnt + 1'b1;
      end
      if (rd_v && valid[rd_idx]) begin
        if (state == ntte_pkg::B_KEY && !found && r_key == cur.key) begin
          found <= 1'b1;
        end
        if (state == ntte_pkg::B_MIN && (!best_v || r_exp < b_exp)) begin
          best_v <= 1'b1;
        end
      end
      if (state == ntte_pkg::B_IDLE && q_valid) begin
        had_old <= 1'b0;
      end else if (set_old) begin
        had_old <= 1'b1;
      end
      if (drop) begin
        valid[drop_idx] <= 1'b0;
        count <= count - 1'b1;
      end else if (ins) begin
        valid[free_idx] <= 1'b1;
        count <= count + 1'b1;
      end
      if ((ev_fire || flush) && pend_v) begin
        ev_valid <= 1'b1;
      end else if (ev_ready) begin
        ev_valid <= 1'b0;
      end
      if (ev_fire) begin
        pend_v <= 1'b1;
      end else if (flush) begin
        pend_v <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    rd_idx <= scan_cnt[IW-1:0];
    if (state == ntte_pkg::B_IDLE && q_valid) begin
      cur <= q_item;
    end
    if (rd_v && valid[rd_idx]) begin
      if (state == ntte_pkg::B_KEY && !found && r_key == cur.key) begin
        f_idx <= rd_idx;
        f_key <= r_key;
        f_dig <= r_dig;
        f_exp <= r_exp;
      end
      if (state == ntte_pkg::B_MIN && (!best_v || r_exp < b_exp)) begin
        b_idx <= rd_idx;
        b_key <= r_key;
        b_exp <= r_exp;
      end
    end
    if ((ev_fire && pend_v) || (flush && pend_v)) begin
      ev_kind <= pend_kind;
      ev_key <= pend_key;
      ev_expiry <= pend_exp;
      ev_last <= flush;
    end
    if (ev_fire) begin
      pend_kind <= ev_k;
      pend_key <= ev_kk;
      pend_exp <= ev_ee;
    end
  end

`ifndef SYNTHESIS
  a_count_matches: assert property (@(posedge clk) disable iff (rst)
    32'(count) == $countones(valid))
    else $error("entry count differs from valid bits");
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= ntte_pkg::DEPTH_C)
    else $error("entry count above table depth");
  a_idle_no_pend: assert property (@(posedge clk) disable iff (rst)
    state == ntte_pkg::B_IDLE |-> !pend_v)
    else $error("held event left over at idle");
  a_fire_room: assert property (@(posedge clk) disable iff (rst)
    (ev_fire || flush) |-> (!ev_valid || ev_ready))
    else $error("event pushed with output stage occupied");
  a_flush_last: assert property (@(posedge clk) disable iff (rst)
    (flush && pend_v) |=> (ev_valid && ev_last))
    else $error("final event not marked last");
`endif

endmodule

// ----- rtl/core/neighbor_table_ttl_expiry_top.sv -----
// Top level of the neighbor table with TTL aging: configuration registers,
// front end and back end. Depends on ntte_pkg, ntte_front, ntte_back.
//
//  channel  | direction | tdata (low bit up)                         | tuser / tlast
//  s_axis   | in        | current_time, neighbor_key, content_digest,| tuser: operation
//           |           | source_mac, caps present flag,             |
//           |           | caps bits, time_to_live                    |
//  m_axis   | out       | event_key, event_expiry                    | tuser: event_kind,
//           |           |                                            | tlast: last_event
//  cfg      | in        | cfg_we, cfg_index, cfg_wdata               |
//
// Each table pass reads one entry per cycle from the entry RAM and ends in a
// decision state: an advert starts with a key search pass, and an advert that
// goes on to insert, or a tick, runs one earliest-expiry pass per eviction plus
// a final one. A two-entry queue takes input while the table works.
// Reset is synchronous and empties the table at once. Output stalls hold the
// sequencer at its next event.
module neighbor_table_ttl_expiry_top (
  input  logic          clk,
  input  logic          rst,
  input  logic          s_axis_tvalid,
  output logic          s_axis_tready,
  input  logic [247:0]  s_axis_tdata,  // current_time, neighbor_key, content_digest,
                                       // source_mac, caps present flag,
                                       // caps bits, time_to_live, zero pad
  input  logic [0:0]    s_axis_tuser,  // operation
  output logic          m_axis_tvalid,
  input  logic          m_axis_tready,
  output logic [95:0]   m_axis_tdata,  // event_key, event_expiry
  output logic [1:0]    m_axis_tuser,  // event_kind
  output logic          m_axis_tlast,
  input  logic          cfg_we,
  input  logic [1:0]    cfg_index,
  input  logic [47:0]   cfg_wdata
);

  logic [ntte_pkg::CNT_W-1:0] neighbor_limit;
  logic [15:0]                cap_mask;
  logic [47:0]                filtered_source_mac;
  logic                       q_valid;
  logic                       q_ready;
  ntte_pkg::item_t            q_item;
  logic [63:0]                ev_key;
  logic [31:0]                ev_expiry;

  always_ff @(posedge clk) begin
    if (rst) begin
      neighbor_limit <= ntte_pkg::LIMIT_RST;
      cap_mask <= ntte_pkg::CAPMASK_RST;
      filtered_source_mac <= '0;
    end else if (cfg_we) begin
      case (ntte_pkg::reg_idx_t'(cfg_index))
        ntte_pkg::REG_LIMIT:   neighbor_limit <= cfg_wdata[ntte_pkg::CNT_W-1:0];
        ntte_pkg::REG_CAPMASK: cap_mask <= cfg_wdata[15:0];
        ntte_pkg::REG_FILTER:  filtered_source_mac <= cfg_wdata;
        default: ;
      endcase
    end
  end

  ntte_front u_front (
    .clk                (clk),
    .rst                (rst),
    .in_valid           (s_axis_tvalid),
    .in_ready           (s_axis_tready),
    .in_op              (s_axis_tuser[0]),
    .in_time            (s_axis_tdata[31:0]),
    .in_key             (s_axis_tdata[95:32]),
    .in_digest          (s_axis_tdata[159:96]),
    .in_src             (s_axis_tdata[207:160]),
    .in_has_caps        (s_axis_tdata[208]),
    .in_caps            (s_axis_tdata[224:209]),
    .in_ttl             (s_axis_tdata[240:225]),
    .cap_mask           (cap_mask),
    .filtered_source_mac(filtered_source_mac),
    .q_valid            (q_valid),
    .q_ready            (q_ready),
    .q_item             (q_item)
  );

  ntte_back u_back (
    .clk           (clk),
    .rst           (rst),
    .neighbor_limit(neighbor_limit),
    .q_valid       (q_valid),
    .q_ready       (q_ready),
    .q_item        (q_item),
    .ev_valid      (m_axis_tvalid),
    .ev_ready      (m_axis_tready),
    .ev_kind       (m_axis_tuser),
    .ev_key        (ev_key),
    .ev_expiry     (ev_expiry),
    .ev_last       (m_axis_tlast)
  );

  assign m_axis_tdata = {ev_expiry, ev_key};

endmodule

// ----- test/neighbor_table_ttl_expiry_top_tb.sv -----
// Testbench for neighbor_table_ttl_expiry_top: streams adverts and ticks,
// predicts the neighbor table events and checks every output transfer.
// Depends on ntte_pkg and the RTL top level.
module neighbor_table_ttl_expiry_top_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import ntte_pkg::*;

  localparam int CYCLE_LIMIT = 3000000;
  localparam int DRAIN = 400;

  typedef struct {
    op_t         op;
    logic [31:0] now;
    logic [63:0] key;
    logic [63:0] digest;
    logic [47:0] src;
    logic        has_caps;
    logic [15:0] caps;
    logic [15:0] ttl;
  } advert_t;

  typedef struct {
    ev_kind_t    kind;
    logic [63:0] key;
    logic [31:0] expiry;
    logic        last;
  } nb_event_t;

  logic          clk = 0;
  logic          rst = 1;
  logic          s_axis_tvalid = 0;
  logic          s_axis_tready;
  logic [247:0]  s_axis_tdata = '0;
  logic [0:0]    s_axis_tuser = '0;
  logic          m_axis_tvalid;
  logic          m_axis_tready = 0;
  logic [95:0]   m_axis_tdata;
  logic [1:0]    m_axis_tuser;
  logic          m_axis_tlast;
  logic          cfg_we = 0;
  logic [1:0]    cfg_index = '0;
  logic [47:0]   cfg_wdata = '0;

  neighbor_table_ttl_expiry_top dut (.*);

  initial forever #5 clk = ~clk;

  advert_t   pending[$];
  nb_event_t event_q[$];
  advert_t   on_bus;
  int        errors = 0;
  int        cycles = 0;
  bit        calm = 0;
  int        hold_req = 0;

  // shadow table and registers
  logic [5:0]  limit_r;
  logic [15:0] capmask_r;
  logic [47:0] filter_r;
  logic        tbl_valid[DEPTH];
  logic [63:0] tbl_key[DEPTH];
  logic [63:0] tbl_digest[DEPTH];
  logic [31:0] tbl_expiry[DEPTH];
  int          tbl_count;

  function automatic void push_event(ev_kind_t k, logic [63:0] key, logic [31:0] ex);
    nb_event_t e;
    e.kind = k; e.key = key; e.expiry = ex; e.last = 0;
    event_q.push_back(e);
  endfunction

  function automatic void age_out(int extra, logic [31:0] now);
    int lim;
    int thr;
    int best;
    lim = (limit_r > DEPTH) ? DEPTH : int'(limit_r);
    thr = (lim > extra) ? lim - extra : 0;
    forever begin
      best = -1;
      for (int i = 0; i < DEPTH; i++)
        if (tbl_valid[i] && (best < 0 || tbl_expiry[i] < tbl_expiry[best])) best = i;
      if (best < 0) break;
      if (!(tbl_count > thr) && tbl_expiry[best] > now) break;
      tbl_valid[best] = 0;
      tbl_count--;
      push_event(EV_REMOVED, tbl_key[best], tbl_expiry[best]);
    end
  endfunction

  function automatic void predict_events(advert_t a);
    int ev_base;
    int old;
    bit keep;
    bit replaced;
    logic [32:0] sum;
    logic [31:0] ex;
    nb_event_t e;
    ev_base = event_q.size();
    old = -1;
    replaced = 0;
    if (a.op == OP_TICK) begin
      age_out(0, a.now);
    end else begin
      sum = {1'b0, a.now} + {17'd0, a.ttl};
      ex = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
      keep = !(a.ttl == 0 || (filter_r != 0 && filter_r == a.src) ||
               (a.has_caps && (a.caps & capmask_r) == 0));
      for (int i = 0; i < DEPTH; i++)
        if (old < 0 && tbl_valid[i] && tbl_key[i] == a.key) old = i;
      if (old >= 0 && !keep) begin
        tbl_valid[old] = 0;
        tbl_count--;
        push_event(EV_REMOVED, tbl_key[old], tbl_expiry[old]);
      end else if (old >= 0 && tbl_digest[old] == a.digest) begin
        tbl_expiry[old] = ex;
        push_event(EV_REFRESHED, a.key, ex);
      end else if (old >= 0 || keep) begin
        if (old >= 0) begin
          tbl_valid[old] = 0;
          tbl_count--;
          replaced = 1;
        end
        age_out(1, a.now);
        for (int i = 0; i < DEPTH; i++)
          if (!tbl_valid[i]) begin
            tbl_valid[i] = 1; tbl_key[i] = a.key; tbl_digest[i] = a.digest;
            tbl_expiry[i] = ex; tbl_count++;
            push_event(replaced ? EV_UPDATED : EV_ADDED, a.key, ex);
            break;
          end
      end
    end
    if (event_q.size() > ev_base) begin
      e = event_q.pop_back();
      e.last = 1;
      event_q.push_back(e);
    end
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 65) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // input driver
  int send_gap = 0;
  always @(posedge clk) begin
    logic nv;
    advert_t a;
    nv = s_axis_tvalid;
    if (rst) begin
      nv = 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        predict_events(on_bus);
        nv = 0;
      end
      if (!nv) begin
        if (send_gap > 0) begin
          send_gap <= send_gap - 1;
        end else if (pending.size() > 0) begin
          a = pending.pop_front();
          on_bus <= a;
          s_axis_tdata <= {7'b0, a.ttl, a.caps, a.has_caps, a.src, a.digest, a.key, a.now};
          s_axis_tuser <= a.op;
          nv = 1;
          send_gap <= pick_gap();
        end
      end
    end
    s_axis_tvalid <= nv;
  end

  // long receiver hold-off, counted here
  int hold_seen = 0;
  int hold_left = 0;
  always @(posedge clk) begin
    if (hold_seen != hold_req) begin
      hold_seen <= hold_req;
      hold_left <= 600;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // output monitor
  int stall = 0;
  always @(posedge clk) begin
    nb_event_t x;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (event_q.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("unexpected event: kind %0d key %h expiry %h last %b",
                   m_axis_tuser, m_axis_tdata[63:0], m_axis_tdata[95:64], m_axis_tlast);
      end else begin
        x = event_q.pop_front();
        if (m_axis_tuser !== x.kind || m_axis_tdata[63:0] !== x.key ||
            m_axis_tdata[95:64] !== x.expiry || m_axis_tlast !== x.last) begin
          errors++;
          if (errors <= 10)
            $display("mismatch: exp kind %0d key %h expiry %h last %b, got %0d %h %h %b",
                     x.kind, x.key, x.expiry, x.last, m_axis_tuser,
                     m_axis_tdata[63:0], m_axis_tdata[95:64], m_axis_tlast);
        end
      end
    end
    if (rst || hold_left > 0 || hold_seen != hold_req) begin
      m_axis_tready <= 0;
    end else if (stall > 0) begin
      stall <= stall - 1;
      m_axis_tready <= 0;
    end else begin
      m_axis_tready <= 1;
      stall <= pick_gap();
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // stimulus
  logic [31:0] t_now = 0;
  logic [63:0] key_pool[48];
  logic [63:0] dig_pool[3];
  logic [47:0] mac_x;

  task automatic write_reg(reg_idx_t idx, logic [47:0] v);
    @(posedge clk);
    cfg_we <= 1; cfg_index <= idx; cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 0;
    case (idx)
      REG_LIMIT: limit_r = v[5:0];
      REG_CAPMASK: capmask_r = v[15:0];
      default: filter_r = v;
    endcase
  endtask

  task automatic settle();
    do begin
      while (pending.size() > 0 || s_axis_tvalid || event_q.size() > 0) @(posedge clk);
      repeat (DRAIN) @(posedge clk);
    end while (pending.size() > 0 || s_axis_tvalid || event_q.size() > 0);
  endtask

  function automatic void adv(logic [63:0] k, logic [63:0] d, logic [15:0] ttl,
                              logic [47:0] src = 48'h1, logic hc = 0, logic [15:0] cp = 0,
                              int dt = 1);
    advert_t a;
    t_now += 32'(dt);
    a.op = OP_ADVERT; a.now = t_now; a.key = k; a.digest = d; a.src = src;
    a.has_caps = hc; a.caps = cp; a.ttl = ttl;
    pending.push_back(a);
  endfunction

  function automatic void tick(int dt);
    advert_t a;
    t_now += 32'(dt);
    a = '{OP_TICK, t_now, {$urandom, $urandom}, {$urandom, $urandom},
          48'({$urandom, $urandom}), 1'($urandom_range(0, 1)), 16'($urandom),
          16'($urandom)};
    pending.push_back(a);
  endfunction

  function automatic void random_items(int count);
    int r;
    logic [63:0] k;
    logic [63:0] d;
    logic [47:0] s;
    logic [15:0] ttl;
    for (int i = 0; i < count; i++) begin
      r = $urandom_range(0, 99);
      if (r < 15) begin
        tick($urandom_range(0, 99) < 10 ? $urandom_range(20, 300) : $urandom_range(0, 5));
      end else begin
        k = ($urandom_range(0, 99) < 85) ? key_pool[$urandom_range(0, 47)] : {$urandom, $urandom};
        d = ($urandom_range(0, 99) < 85) ? dig_pool[$urandom_range(0, 2)] ^ k
                                         : {$urandom, $urandom};
        s = ($urandom_range(0, 99) < 10) ? mac_x : 48'({$urandom, $urandom});
        r = $urandom_range(0, 99);
        ttl = (r < 8) ? 16'd0 : (r < 12) ? 16'hFFFF : 16'($urandom_range(1, 300));
        adv(k, d, ttl, s, 1'($urandom_range(0, 1)), 16'($urandom), $urandom_range(0, 4));
      end
    end
  endfunction

  initial begin
    limit_r = LIMIT_RST; capmask_r = CAPMASK_RST; filter_r = '0; tbl_count = 0;
    for (int i = 0; i < DEPTH; i++) tbl_valid[i] = 0;
    foreach (key_pool[i]) key_pool[i] = {$urandom, $urandom};
    foreach (dig_pool[i]) dig_pool[i] = {$urandom, $urandom};
    mac_x = 48'({$urandom, $urandom}) | 48'h1;
    repeat (7) @(posedge clk);
    rst <= 0;

    // refresh, update, withdraw, extremes, expiry
    calm = 1;
    adv(64'h11, 64'hA, 16'd10);
    adv(64'h11, 64'hA, 16'd20);
    adv(64'h11, 64'hB, 16'd30);
    adv(64'h22, 64'hC, 16'hFFFF, 48'h2, 1, 16'hFFFF);
    adv(64'h11, 64'hB, 16'd0);
    adv(64'h33, 64'hD, 16'd0);
    adv('1, '1, 16'd1, '1, 1, 16'h8000);
    adv('0, '0, 16'd5, 48'h1, 0, 16'h0);
    tick(3);
    settle();

    // filtering, capability mask, small limit with evictions
    calm = 0;
    write_reg(REG_FILTER, mac_x);
    write_reg(REG_CAPMASK, 16'h0001);
    write_reg(REG_LIMIT, 6'd2);
    adv(64'h22, 64'hC, 16'd50, mac_x);
    adv(64'h44, 64'hE, 16'd50, 48'h3, 1, 16'h0002);
    adv(64'h55, 64'hF, 16'd40, 48'h3, 0, 16'h0);
    adv(64'h66, 64'hF, 16'd60, 48'h3, 1, 16'h0001);
    adv(64'h77, 64'hF, 16'd70);
    adv(64'h77, 64'h1F, 16'd80);
    settle();
    write_reg(REG_LIMIT, 6'd0);
    write_reg(REG_CAPMASK, 16'h0000);
    adv(64'h88, 64'h1, 16'd9, 48'h3, 1, 16'hFFFF);
    adv(64'h88, 64'h1, 16'd9);
    tick(1);
    settle();

    // random phases across register settings; hold and sender pause
    write_reg(REG_LIMIT, 6'd63);
    write_reg(REG_CAPMASK, 16'hFFFF);
    write_reg(REG_FILTER, 48'h0);
    random_items(35);
    hold_req++;
    settle();
    write_reg(REG_LIMIT, 6'($urandom_range(1, 8)));
    write_reg(REG_CAPMASK, 16'($urandom_range(1, 65535)));
    write_reg(REG_FILTER, mac_x);
    calm = 1;
    random_items(25);
    settle();
    calm = 0;
    write_reg(REG_LIMIT, 6'd32);
    write_reg(REG_CAPMASK, 16'h0F0F);
    hold_req++;
    random_items(25);
    settle();

    // time near the top: saturated expiry, then all expire
    write_reg(REG_LIMIT, 6'd1);
    tick(0);
    t_now = 32'hFFFF_FF00;
    adv(64'h99, 64'h2, 16'hFFFF);
    settle();
    write_reg(REG_LIMIT, 6'd32);
    settle();
    adv(64'hAA, 64'h3, 16'hFFFF);
    adv(64'hBB, 64'h4, 16'h0100, 48'h1, 0, 16'h0, 0);
    t_now = 32'hFFFF_FFFF;
    tick(0);
    settle();

    if (errors == 0 && event_q.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end
endmodule

// ----- filelist.f -----
rtl/core/ntte_pkg.sv
rtl/core/ntte_ram.sv
rtl/core/ntte_front.sv
rtl/core/ntte_back.sv
rtl/core/neighbor_table_ttl_expiry_top.sv
test/neighbor_table_ttl_expiry_top_tb.sv
